// ===== rtl/core/gb5_pkg.sv =====
// Shared constants, types and codes of the 5x5 binomial blur.
package gb5_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int RING_ROWS  = 8;
	localparam int RING_W     = $clog2(RING_ROWS);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 12;
	localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int TAPS       = 5;
	localparam int CH_N       = 4;
	localparam int CH_W       = 8;
	localparam int PIX_W      = CH_N * CH_W;
	localparam int VSUM_W     = CH_W + 4;
	localparam int HSUM_W     = VSUM_W + 4;
	localparam int OUT_DEPTH  = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [2:0] TAP_WT [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

	typedef struct packed {
		logic                             vld;
		logic [COL_W-1:0]                 col;
		logic [TAPS-1:0][RING_W-1:0]      rsel;
		logic                             fill;
		logic                             emit;
		logic                             last;
	} fetch_op_t;

	typedef struct packed {
		logic             vld;
		logic             last;
		logic [PIX_W-1:0] pix;
	} result_t;

endpackage

// ===== rtl/core/gb5_filter.sv =====
// Line store, vertical pass, column window and horizontal pass of the blur.
module gb5_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [gb5_pkg::COL_W-1:0]             wr_col,
	input  logic [gb5_pkg::RING_W-1:0]            wr_lane,
	input  logic [gb5_pkg::PIX_W-1:0]             wr_pix,
	input  gb5_pkg::fetch_op_t                    op,
	output gb5_pkg::result_t                      res
);

	logic [gb5_pkg::RING_ROWS-1:0][gb5_pkg::PIX_W-1:0] mem [gb5_pkg::MAX_WIDTH];
	logic [gb5_pkg::RING_ROWS-1:0][gb5_pkg::PIX_W-1:0] rd_s2;
	gb5_pkg::fetch_op_t                                op_s2;
	logic [gb5_pkg::CH_N-1:0][gb5_pkg::VSUM_W-1:0]     vsum;
	logic [gb5_pkg::CH_N-1:0][gb5_pkg::VSUM_W-1:0]     win_q [gb5_pkg::TAPS];
	logic                                              vld_s3;
	logic                                              last_s3;
	logic [gb5_pkg::HSUM_W-1:0]                        hsum;

	// one write lane per ring row, one column read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_col][wr_lane] <= wr_pix;
		end
		if (op.vld) begin
			rd_s2 <= mem[op.col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2   <= '0;
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			op_s2   <= op;
			vld_s3  <= op_s2.vld && op_s2.emit;
			last_s3 <= op_s2.last;
		end
	end

	// vertical pass over the five clamped ring rows
	always_comb begin
		for (int ch = 0; ch < gb5_pkg::CH_N; ch++) begin
			vsum[ch] = '0;
			for (int k = 0; k < gb5_pkg::TAPS; k++) begin
				vsum[ch] = vsum[ch]
					+ gb5_pkg::VSUM_W'(rd_s2[op_s2.rsel[k]][ch*gb5_pkg::CH_W +: gb5_pkg::CH_W])
					* gb5_pkg::VSUM_W'(gb5_pkg::TAP_WT[k]);
			end
		end
	end

	// fill replicates the left edge column, otherwise shift one column in
	always_ff @(posedge clk) begin
		if (op_s2.vld) begin
			for (int k = 0; k < gb5_pkg::TAPS; k++) begin
				if (op_s2.fill || k == gb5_pkg::TAPS - 1) begin
					win_q[k] <= vsum;
				end else begin
					win_q[k] <= win_q[k+1];
				end
			end
		end
	end

	always_comb begin
		res.vld  = vld_s3;
		res.last = last_s3;
		res.pix  = '0;
		hsum     = '0;
		for (int ch = 0; ch < gb5_pkg::CH_N; ch++) begin
			hsum = '0;
			for (int k = 0; k < gb5_pkg::TAPS; k++) begin
				hsum = hsum + gb5_pkg::HSUM_W'(win_q[k][ch])
					* gb5_pkg::HSUM_W'(gb5_pkg::TAP_WT[k]);
			end
			res.pix[ch*gb5_pkg::CH_W +: gb5_pkg::CH_W] = hsum[gb5_pkg::HSUM_W-1 -: gb5_pkg::CH_W];
		end
	end

endmodule

// ===== rtl/core/gaussian_blur_5x5_rgba.sv =====
// Top level of the 5x5 binomial blur for four-channel 8-bit pixels.
// Usage:
//  Input channel (in_valid/in_stall): one request per pixel in raster order
//  (kind = 0) or a flush tick (kind = 1). A request is taken at a clock edge
//  with in_valid high and in_stall low.
//  Output channel (out_valid/out_stall): one blurred pixel per frame pixel,
//  frame_last marks the final pixel of the frame.
//  Output for pixel i is produced by the request that brings pixel
//  i + 2*width + 2; after the frame's last pixel each flush tick drains one.
//  Path: a result passes the fetch register, the line store read register and
//  the column window before it enters the output buffer; at a row start the preloads come first.
//  Throughput: one request per cycle, except while the output buffer is fully
//  committed and at the first output of each row, when the single read port of
//  the line store has to load three columns into the window before that output can leave.
//  Stall: results queue in an eight-entry output buffer, so requests keep
//  flowing while the receiver stalls until the buffer is committed.
//  Reset: sizes return to 2048 x 2048 and the frame position to the start;
//  the line store needs no clearing. A configuration write also restarts
//  the frame and is to be issued while the block is idle.
module gaussian_blur_5x5_rgba (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [31:0]                       pixel_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       pixel_out,
	output logic                              frame_last,
	input  logic                              cfg_we,
	input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gb5_pkg::DIM_W-1:0]         cfg_data
);

	localparam int OCC_W = $clog2(gb5_pkg::OUT_DEPTH + 1);
	localparam int PTR_W = $clog2(gb5_pkg::OUT_DEPTH);

	logic [gb5_pkg::DIM_W-1:0]                  w_q, h_q, wm1;
	logic [gb5_pkg::CNT_W-1:0]                  total_q, recv_q, emit_q;
	logic [gb5_pkg::COL_W-1:0]                  in_col_q, out_col_q;
	logic [gb5_pkg::ROW_W-1:0]                  in_row_q, out_row_q;
	logic [1:0]                                 pre_q;
	gb5_pkg::fetch_op_t                         op_s1;
	logic [gb5_pkg::TAPS-1:0][gb5_pkg::RING_W-1:0] job_rsel_q, rsel;
	logic                                       job_last_q;
	logic [OCC_W-1:0]                           occ_q;
	logic [gb5_pkg::PIX_W:0]                    fifo_q [gb5_pkg::OUT_DEPTH];
	logic [PTR_W-1:0]                           wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]                           fcnt_q;
	gb5_pkg::result_t                           res;

	logic                                       in_acc, out_acc, full, pix_wr, do_emit, is_last;
	logic [gb5_pkg::CNT_W:0]                    thresh;
	logic [gb5_pkg::DIM_W-1:0]                  mul_a, mul_b;
	logic [2*gb5_pkg::DIM_W-1:0]                prod;

	// saturate a size register to 1..hi
	function automatic logic [gb5_pkg::DIM_W-1:0] clamp_dim(
		input logic [gb5_pkg::DIM_W-1:0] v, input int unsigned hi);
		logic [gb5_pkg::DIM_W-1:0] r;
		r = v;
		if (v == '0) r = gb5_pkg::DIM_W'(1);
		else if (32'(v) > hi) r = gb5_pkg::DIM_W'(hi);
		return r;
	endfunction

	// ring lane of row r+k-2 clamped to the frame
	function automatic logic [gb5_pkg::RING_W-1:0] row_pick(
		input logic [gb5_pkg::ROW_W-1:0] r, input logic [2:0] k,
		input logic [gb5_pkg::DIM_W-1:0] h);
		logic [gb5_pkg::DIM_W:0] t;
		logic [gb5_pkg::DIM_W:0] hm1;
		t   = (gb5_pkg::DIM_W+1)'(r) + (gb5_pkg::DIM_W+1)'(k);
		hm1 = {1'b0, h} - (gb5_pkg::DIM_W+1)'(1);
		if (t < (gb5_pkg::DIM_W+1)'(2)) t = '0;
		else t = t - (gb5_pkg::DIM_W+1)'(2);
		if (t > hm1) t = hm1;
		return t[gb5_pkg::RING_W-1:0];
	endfunction

	// clamp a column to the right edge
	function automatic logic [gb5_pkg::COL_W-1:0] col_pick(
		input logic [gb5_pkg::DIM_W-1:0] x, input logic [gb5_pkg::DIM_W-1:0] m);
		return (x > m) ? m[gb5_pkg::COL_W-1:0] : x[gb5_pkg::COL_W-1:0];
	endfunction

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign wm1      = w_q - gb5_pkg::DIM_W'(1);
	assign full     = recv_q >= total_q;
	assign pix_wr   = in_acc && !kind && !full;
	assign thresh   = {1'b0, emit_q} + (gb5_pkg::CNT_W+1)'({w_q, 1'b0})
		+ (gb5_pkg::CNT_W+1)'(2);
	assign do_emit  = in_acc && ((!kind && !full && ({1'b0, recv_q} >= thresh))
		|| (kind && full && (emit_q < total_q)));
	assign is_last  = (emit_q + gb5_pkg::CNT_W'(1)) == total_q;

	// hold off new requests while a row start preloads or the queue is committed
	assign in_stall = (pre_q != 2'd0) || (occ_q == OCC_W'(gb5_pkg::OUT_DEPTH));

	always_comb begin
		for (int k = 0; k < gb5_pkg::TAPS; k++) begin
			rsel[k] = row_pick(out_row_q, 3'(k), h_q);
		end
	end

	// frame size product, operands taken from the register being written
	always_comb begin
		mul_a = w_q;
		mul_b = h_q;
		if (cfg_index == gb5_pkg::REG_FRAME_WIDTH) begin
			mul_a = clamp_dim(cfg_data, gb5_pkg::MAX_WIDTH);
		end
		if (cfg_index == gb5_pkg::REG_FRAME_HEIGHT) begin
			mul_b = clamp_dim(cfg_data, gb5_pkg::MAX_HEIGHT);
		end
		prod = mul_a * mul_b;
	end

	// frame position counters and size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= gb5_pkg::DIM_W'(gb5_pkg::MAX_WIDTH);
			h_q       <= gb5_pkg::DIM_W'(gb5_pkg::MAX_HEIGHT);
			total_q   <= gb5_pkg::CNT_W'(gb5_pkg::MAX_WIDTH * gb5_pkg::MAX_HEIGHT);
			recv_q    <= '0;
			emit_q    <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			w_q       <= mul_a;
			h_q       <= mul_b;
			total_q   <= gb5_pkg::CNT_W'(prod);
			recv_q    <= '0;
			emit_q    <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (pix_wr) begin
				recv_q <= recv_q + gb5_pkg::CNT_W'(1);
				if (gb5_pkg::DIM_W'(in_col_q) + gb5_pkg::DIM_W'(1) >= w_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + gb5_pkg::ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + gb5_pkg::COL_W'(1);
				end
			end
			if (do_emit) begin
				if (is_last) begin
					// end of frame: return the frame position counters to the start
					recv_q    <= '0;
					emit_q    <= '0;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					emit_q <= emit_q + gb5_pkg::CNT_W'(1);
					if (gb5_pkg::DIM_W'(out_col_q) + gb5_pkg::DIM_W'(1) >= w_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + gb5_pkg::ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + gb5_pkg::COL_W'(1);
					end
				end
			end
		end
	end

	// column fetch sequencer: a row start loads three columns, then one per output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q      <= 2'd0;
			op_s1      <= '0;
			job_rsel_q <= '0;
			job_last_q <= 1'b0;
		end else begin
			priority if (do_emit && out_col_q == '0) begin
				op_s1.vld  <= 1'b1;
				pre_q      <= 2'd2;
				op_s1.col  <= '0;
				op_s1.rsel <= rsel;
				op_s1.fill <= 1'b1;
				op_s1.emit <= 1'b0;
				op_s1.last <= 1'b0;
				job_rsel_q <= rsel;
				job_last_q <= is_last;
			end else if (do_emit) begin
				op_s1.vld  <= 1'b1;
				op_s1.col  <= col_pick(gb5_pkg::DIM_W'(out_col_q) + gb5_pkg::DIM_W'(2), wm1);
				op_s1.rsel <= rsel;
				op_s1.fill <= 1'b0;
				op_s1.emit <= 1'b1;
				op_s1.last <= is_last;
			end else if (pre_q == 2'd2) begin
				op_s1.vld  <= 1'b1;
				pre_q      <= 2'd1;
				op_s1.col  <= col_pick(gb5_pkg::DIM_W'(1), wm1);
				op_s1.rsel <= job_rsel_q;
				op_s1.fill <= 1'b0;
				op_s1.emit <= 1'b0;
				op_s1.last <= 1'b0;
			end else if (pre_q == 2'd1) begin
				op_s1.vld  <= 1'b1;
				pre_q      <= 2'd0;
				op_s1.col  <= col_pick(gb5_pkg::DIM_W'(2), wm1);
				op_s1.rsel <= job_rsel_q;
				op_s1.fill <= 1'b0;
				op_s1.emit <= 1'b1;
				op_s1.last <= job_last_q;
			end else begin
				op_s1.vld  <= 1'b0;
			end
		end
	end

	gb5_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pix_wr),
		.wr_col  (in_col_q),
		.wr_lane (in_row_q[gb5_pkg::RING_W-1:0]),
		.wr_pix  (pixel_in),
		.op      (op_s1),
		.res     (res)
	);

	// committed results: counted at issue, released when the receiver takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			fcnt_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			occ_q  <= occ_q + OCC_W'(do_emit) - OCC_W'(out_acc);
			fcnt_q <= fcnt_q + OCC_W'(res.vld) - OCC_W'(out_acc);
			if (res.vld) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			fifo_q[wr_ptr_q] <= {res.last, res.pix};
		end
	end

	assign out_valid  = fcnt_q != '0;
	assign pixel_out  = fifo_q[rd_ptr_q][gb5_pkg::PIX_W-1:0];
	assign frame_last = fifo_q[rd_ptr_q][gb5_pkg::PIX_W];

endmodule
